[design/point_in_polygon_classifier_defines.svh]
// ----------------------------------------------------------------------------
// point_in_polygon_classifier_defines
// assertion macros shared by the classifier modules
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_CLASSIFIER_DEFINES_SVH
`define POINT_IN_POLYGON_CLASSIFIER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PIPC_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PIPC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pipc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipc_pkg
// types and constants of the point-in-polygon classifier
// ----------------------------------------------------------------------------
package pipc_pkg;

    localparam int VIDX_W = 6;
    localparam int VCNT_W = 7;

    typedef enum logic [0:0] {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        LOC_OUTSIDE = 2'd0,
        LOC_INSIDE  = 2'd1,
        LOC_EDGE    = 2'd2,
        LOC_VERTEX  = 2'd3
    } loc_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // tag that travels with one edge through the edge unit
    typedef struct packed {
        logic valid;
        logic last;
    } edge_tag_t;

    // per-edge result of the edge unit
    typedef struct packed {
        logic valid;
        logic last;
        logic vtx_hit;
        logic edge_hit;
        logic wind_up;
        logic wind_down;
    } edge_flags_t;

endpackage

[design/pipc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipc_if
// handshake channels of the point-in-polygon classifier
// ----------------------------------------------------------------------------
interface pipc_req_if #(
    parameter int COORD_BITS = 16
);
    logic                            valid;
    logic                            ready;
    pipc_pkg::cmd_t                  cmd;
    logic [pipc_pkg::VIDX_W-1:0]     vertex_index;
    logic signed [COORD_BITS-1:0]    point_x;
    logic signed [COORD_BITS-1:0]    point_y;

    modport source (output valid, cmd, vertex_index, point_x, point_y, input ready);
    modport sink   (input valid, cmd, vertex_index, point_x, point_y, output ready);
endinterface

interface pipc_rsp_if;
    logic           valid;
    logic           ready;
    pipc_pkg::loc_t location;

    modport source (output valid, location, input ready);
    modport sink   (input valid, location, output ready);
endinterface

interface pipc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [pipc_pkg::VCNT_W-1:0] vertex_count;

    modport source (output valid, vertex_count, input ready);
    modport sink   (input valid, vertex_count, output ready);
endinterface

[design/pipc_vertex_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipc_vertex_store
// polygon vertex memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
module pipc_vertex_store #(
    parameter int DEPTH = 64,
    parameter int CW    = 16
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [2*CW-1:0]            wr_data,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr_b,
    output logic [2*CW-1:0]            rd_data_a,
    output logic [2*CW-1:0]            rd_data_b
);
    import pipc_pkg::*;

    // x in the upper half, y in the lower half
    logic [2*CW-1:0] mem [DEPTH];
    logic [2*CW-1:0] rd_a_reg;
    logic [2*CW-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

[design/pipc_edge_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipc_edge_unit
// shared two-stage cross/dot product unit, classifies one edge per cycle
// ----------------------------------------------------------------------------
module pipc_edge_unit #(
    parameter int CW = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic signed [CW-1:0]    qx,
    input  logic signed [CW-1:0]    qy,
    input  logic signed [CW-1:0]    ax,
    input  logic signed [CW-1:0]    ay,
    input  logic signed [CW-1:0]    bx,
    input  logic signed [CW-1:0]    by,
    input  pipc_pkg::edge_tag_t     tag,
    output pipc_pkg::edge_flags_t   flags
);
    import pipc_pkg::*;

    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] dqx_a;
    logic signed [DW-1:0] dqy_a;
    logic signed [DW-1:0] dqx_b;
    logic signed [DW-1:0] dqy_b;
    logic signed [DW-1:0] ebx;
    logic signed [DW-1:0] eby;

    logic signed [PW-1:0] pc0_reg;
    logic signed [PW-1:0] pc1_reg;
    logic signed [PW-1:0] pd0_reg;
    logic signed [PW-1:0] pd1_reg;
    logic                 eq_reg;
    logic                 a_below_reg;
    logic                 b_below_reg;
    edge_tag_t            tag_reg;

    logic signed [PW:0]   cross_v;
    logic signed [PW:0]   dot_v;
    edge_flags_t          flags_next;
    edge_flags_t          flags_reg;

    // stage 1: differences and the four products
    assign dqx_a = {qx[CW-1], qx} - {ax[CW-1], ax};
    assign dqy_a = {qy[CW-1], qy} - {ay[CW-1], ay};
    assign dqx_b = {qx[CW-1], qx} - {bx[CW-1], bx};
    assign dqy_b = {qy[CW-1], qy} - {by[CW-1], by};
    assign ebx   = {bx[CW-1], bx} - {ax[CW-1], ax};
    assign eby   = {by[CW-1], by} - {ay[CW-1], ay};

    always_ff @(posedge clk)
    begin
        pc0_reg     <= dqx_a * eby;
        pc1_reg     <= dqy_a * ebx;
        pd0_reg     <= dqx_a * dqx_b;
        pd1_reg     <= dqy_a * dqy_b;
        eq_reg      <= (ax == qx) && (ay == qy);
        a_below_reg <= ay < qy;
        b_below_reg <= by < qy;
    end

    // stage 2: cross sign, dot sign, winding direction
    assign cross_v = {pc0_reg[PW-1], pc0_reg} - {pc1_reg[PW-1], pc1_reg};
    assign dot_v   = {pd0_reg[PW-1], pd0_reg} + {pd1_reg[PW-1], pd1_reg};

    always_comb
    begin
        flags_next.valid     = tag_reg.valid;
        flags_next.last      = tag_reg.last;
        flags_next.vtx_hit   = eq_reg;
        flags_next.edge_hit  = (cross_v == '0) && (dot_v[PW] || (dot_v == '0));
        // point left of an upward edge: cross of (q-a, b-a) is negative
        flags_next.wind_up   = cross_v[PW] && a_below_reg && !b_below_reg;
        flags_next.wind_down = !cross_v[PW] && (cross_v != '0) && b_below_reg && !a_below_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg   <= '0;
            flags_reg <= '0;
        end
        else
        begin
            tag_reg   <= tag;
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

[design/point_in_polygon_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_classifier
// nonzero winding point-in-polygon test over a stored vertex list
// ----------------------------------------------------------------------------
// channel  dir   fields                                  use
// req      in    cmd, vertex_index, point_x, point_y      vertex write or query
// rsp      out   location                                 one item per query
// cfg      in    vertex_count                             polygon size
//
// a vertex write is stored when accepted; a query runs ST_RUN, where the
// two-port vertex store feeds the edge unit one edge a cycle, then ST_DRAIN
// and ST_FINISH (ST_FINISH alone when n is 0), n being vertex_count capped
// at MAX_VERTICES. a finished result waits in the output register while the next
// item is accepted; a query that finishes while it is held waits for it. reset
// needs no clearing; slots must be written before they are read (not enforced).
// ----------------------------------------------------------------------------
`include "point_in_polygon_classifier_defines.svh"

module point_in_polygon_classifier #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    pipc_req_if.sink    req,
    pipc_rsp_if.source  rsp,
    pipc_cfg_if.sink    cfg
);
    import pipc_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int WW = NW + 1;

    state_t                  state_reg, state_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic [NW-1:0]           n_reg, n_next;
    logic signed [COORD_BITS-1:0] qx_reg, qy_reg;
    logic                    any_vtx_reg, any_vtx_next;
    logic                    any_edge_reg, any_edge_next;
    logic signed [WW-1:0]    wind_reg, wind_next;
    edge_tag_t               iss_reg, iss_next;
    logic                    out_valid_reg, out_valid_next;
    loc_t                    loc_reg, loc_next;
    logic [VCNT_W-1:0]       vcount_reg;

    logic                    req_fire;
    logic                    q_start;
    logic                    wr_en;
    logic [31:0]             cnt_ext;
    logic [NW-1:0]           n_sat;
    logic                    last_edge;
    logic [AW-1:0]           idx_b;
    logic [2*COORD_BITS-1:0] rd_a;
    logic [2*COORD_BITS-1:0] rd_b;
    edge_flags_t             flags;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign q_start   = req_fire && (req.cmd == CMD_QUERY);
    // slots at or above the store depth are dropped
    assign wr_en     = req_fire && (req.cmd == CMD_WRITE)
                       && (32'(req.vertex_index) < 32'(MAX_VERTICES));

    assign cnt_ext   = 32'(vcount_reg);
    assign n_sat     = (cnt_ext > 32'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(cnt_ext);
    assign last_edge = (NW'(idx_reg) + NW'(1)) == n_reg;
    assign idx_b     = last_edge ? '0 : idx_reg + AW'(1);

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            vcount_reg <= cfg.vertex_count;
        end
    end

    pipc_vertex_store #(
        .DEPTH (MAX_VERTICES),
        .CW    (COORD_BITS)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (AW'(req.vertex_index)),
        .wr_data   ({req.point_x, req.point_y}),
        .rd_addr_a (idx_reg),
        .rd_addr_b (idx_b),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    pipc_edge_unit #(
        .CW (COORD_BITS)
    ) u_edge (
        .clk   (clk),
        .rst_n (rst_n),
        .qx    (qx_reg),
        .qy    (qy_reg),
        .ax    (rd_a[2*COORD_BITS-1:COORD_BITS]),
        .ay    (rd_a[COORD_BITS-1:0]),
        .bx    (rd_b[2*COORD_BITS-1:COORD_BITS]),
        .by    (rd_b[COORD_BITS-1:0]),
        .tag   (iss_reg),
        .flags (flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            n_reg         <= '0;
            any_vtx_reg   <= 1'b0;
            any_edge_reg  <= 1'b0;
            wind_reg      <= '0;
            iss_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            any_vtx_reg   <= any_vtx_next;
            any_edge_reg  <= any_edge_next;
            wind_reg      <= wind_next;
            iss_reg       <= iss_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_start)
        begin
            qx_reg <= req.point_x;
            qy_reg <= req.point_y;
        end
        loc_reg <= loc_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        iss_next       = '0;
        out_valid_next = out_valid_reg && !rsp.ready;
        loc_next       = loc_reg;
        any_vtx_next   = any_vtx_reg;
        any_edge_next  = any_edge_reg;
        wind_next      = wind_reg;

        // fold in each finished edge
        if (flags.valid)
        begin
            any_vtx_next  = any_vtx_reg || flags.vtx_hit;
            any_edge_next = any_edge_reg || flags.edge_hit;
            if (flags.wind_up)
            begin
                wind_next = wind_reg + WW'(1);
            end
            else if (flags.wind_down)
            begin
                wind_next = wind_reg - WW'(1);
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_start)
                begin
                    idx_next      = '0;
                    n_next        = n_sat;
                    any_vtx_next  = 1'b0;
                    any_edge_next = 1'b0;
                    wind_next     = '0;
                    state_next    = (n_sat == '0) ? ST_FINISH : ST_RUN;
                end
            end
            ST_RUN:
            begin
                iss_next.valid = 1'b1;
                iss_next.last  = last_edge;
                if (last_edge)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (flags.valid && flags.last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (any_vtx_reg)
                    begin
                        loc_next = LOC_VERTEX;
                    end
                    else if (any_edge_reg)
                    begin
                        loc_next = LOC_EDGE;
                    end
                    else if (wind_reg != '0)
                    begin
                        loc_next = LOC_INSIDE;
                    end
                    else
                    begin
                        loc_next = LOC_OUTSIDE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.location = loc_reg;

    `PIPC_ASSERT_IMPL(a_idle_pipe_empty, state_reg == ST_IDLE, !flags.valid && !iss_reg.valid, "edge pipeline busy while idle")
    `PIPC_ASSERT_IMPL(a_idx_in_range, state_reg == ST_RUN, NW'(idx_reg) < n_reg, "edge index past vertex count")
    `PIPC_ASSERT_NEXT(a_last_to_finish, flags.valid && flags.last, state_reg == ST_FINISH, "last edge did not close the query")

endmodule
